// File: src/mbet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Fixed-point formats, iteration limits, register indexes, the shared
// multiplier request/response words and the sequencer state type.
// ----------------------------------------------------------------------------
package mbet_pkg;

    localparam int FRAC_BITS  = 28;   // fraction bits of the Q4.28 plane format
    localparam int MAX_ITER   = 255;  // z updates allowed per pixel
    localparam int SHADES     = 16;   // palette size, shade = count mod SHADES

    localparam int OPW        = 34;   // signed multiplier operand
    localparam int MAGW       = 32;   // operand magnitude into the multiplier
    localparam int PRODW      = 2 * MAGW;
    localparam int WW         = 45;   // wide signed values (mapped point, results)
    localparam int CNTW       = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_PIXEL_STEP   = 3'd2;
    localparam t_cfg_idx CFG_CENTER_REAL  = 3'd3;
    localparam t_cfg_idx CFG_CENTER_IMAG  = 3'd4;

    typedef logic signed [OPW-1:0] t_opnd;
    typedef logic signed [WW-1:0]  t_wide;

    localparam t_wide FX_ONE       = t_wide'(1) <<< FRAC_BITS;
    localparam t_wide FX_TWO       = FX_ONE <<< 1;
    localparam t_wide FX_FOUR      = FX_ONE <<< 2;
    localparam t_wide FX_QUARTER   = FX_ONE >>> 2;
    localparam t_wide FX_SIXTEENTH = FX_ONE >>> 4;

    // Destination of a product; travels with the operation through the unit.
    typedef enum logic [3:0] {
        DST_NONE,
        DST_CR,
        DST_CI,
        DST_YY,
        DST_XM2,
        DST_XP2,
        DST_CARD,
        DST_ZR2,
        DST_ZI2,
        DST_P
    } t_dst;

    typedef struct packed {
        logic  valid;
        logic  shift;   // drop FRAC_BITS from the magnitude (fixed-point product)
        t_dst  dst;
        t_opnd a;
        t_opnd b;
    } t_mul_req;

    typedef struct packed {
        logic  valid;   // product at the output this cycle
        logic  pending; // an operation still sits in the first stage
        t_dst  dst;
        t_wide value;
    } t_mul_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MAP0,
        S_MAP1,
        S_MAP_W,
        S_RANGE,
        S_INT1,
        S_INT2,
        S_INT_W1,
        S_INTQ,
        S_INTQX,
        S_INT3,
        S_INT_W2,
        S_INTDEC,
        S_UPD,
        S_IT0,
        S_IT1,
        S_IT2,
        S_IT_W,
        S_DONE
    } t_state;

endpackage

// File: src/mandelbrot_escape_time_pixel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel core
// Maps a pixel to a point c of the complex plane, screens the main cardioid
// and the period-2 bulb, and iterates z = z^2 + c on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one word per pixel, tdata = {pixel_row, pixel_col}.
//   Master stream: one word per pixel, in input order, tdata carries
//   {shade_index, is_black, iter_count}.
//   Config port: write image width/height, pixel step and view center while
//   no pixel is in flight; writes to unknown indexes are dropped.
// Sequence:
//   Every product goes through the two-stage shared multiplier. After a
//   pixel is accepted, the core maps it to c and checks the range, screens
//   the interior when |Re c| < 2 and |Im c| < 2, runs each z update as
//   three products zr*zr, zi*zi, zr*zi plus drain, and loads the output.
//   A point outside that square escapes on its first update, interior
//   pixels skip the iteration, and the count stops at the limit MAX_ITER.
//   The core takes one pixel at a time: tready is high only when idle,
//   which the core becomes as the finished word is loaded.
// Reset (synchronous, active low): registers return to 1024 x 1024, step
//   1/256, center (-0.5, 0); the pipeline empties and no word is pending.
// Stall: a finished word waits in the output register; the next pixel is
//   accepted meanwhile and its result holds until the register frees.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbet_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // pixel input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [23:0]                       i_s_tdata,  // [11:0] pixel_col, [23:12] pixel_row
    // result output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [15:0]                       o_m_tdata   // [7:0] iter_count, [8] is_black,
                                                          // [12:9] shade_index, [15:13] zero
);
    import mbet_pkg::*;

    // configuration registers
    logic [12:0]         r_width;
    logic [12:0]         r_height;
    logic [30:0]         r_step;
    logic signed [31:0]  r_cen_re;
    logic signed [31:0]  r_cen_im;

    // sequencer and datapath registers
    t_state              r_state,  n_state;
    logic signed [12:0]  r_dx,     n_dx;
    logic signed [12:0]  r_dy,     n_dy;
    t_wide               r_cr,     n_cr;
    t_wide               r_ci,     n_ci;
    t_opnd               r_xm,     n_xm;
    t_opnd               r_xp,     n_xp;
    t_opnd               r_yy,     n_yy;
    t_opnd               r_xm2,    n_xm2;
    t_opnd               r_xp2,    n_xp2;
    t_opnd               r_q,      n_q;
    t_opnd               r_qx,     n_qx;
    t_wide               r_card,   n_card;
    t_opnd               r_zr,     n_zr;
    t_opnd               r_zi,     n_zi;
    t_opnd               r_zr2,    n_zr2;
    t_opnd               r_zi2,    n_zi2;
    t_opnd               r_p,      n_p;
    logic [CNTW-1:0]     r_count,  n_count;
    logic [CNTW-1:0]     r_shade,  n_shade;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [CNTW-1:0]     r_out_count, n_out_count;
    logic                r_out_black, n_out_black;
    logic [3:0]          r_out_shade, n_out_shade;

    t_mul_req            w_req;
    t_mul_rsp            w_rsp;

    logic signed [12:0]  w_col_dx;
    logic signed [12:0]  w_row_dy;
    logic                w_in_range;
    logic                w_interior;
    t_wide               w_sum;
    t_wide               w_zr_new;
    t_wide               w_zi_new;
    logic                w_big;
    logic [CNTW-1:0]     w_cnt_next;
    logic [CNTW-1:0]     w_shade_next;
    logic                w_out_free;

    mbet_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // ------------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd1024;
            r_height <= 13'd1024;
            r_step   <= 31'd1048576;
            r_cen_re <= -32'sd134217728;
            r_cen_im <= 32'sd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata[12:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_wdata[12:0];
                CFG_PIXEL_STEP:   r_step   <= i_cfg_wdata[30:0];
                CFG_CENTER_REAL:  r_cen_re <= $signed(i_cfg_wdata);
                CFG_CENTER_IMAG:  r_cen_im <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Datapath terms
    // ------------------------------------------------------------------------
    // Center on the integer half of width and height.
    assign w_col_dx = $signed({1'b0, i_s_tdata[11:0]})  - $signed({1'b0, r_width[12:1]});
    assign w_row_dy = $signed({1'b0, i_s_tdata[23:12]}) - $signed({1'b0, r_height[12:1]});

    assign w_in_range = (r_cr > -FX_TWO) && (r_cr < FX_TWO) &&
                        (r_ci > -FX_TWO) && (r_ci < FX_TWO);

    // Cardioid in the square-root-free form, or the period-2 bulb.
    assign w_interior = (r_card <= t_wide'(r_yy >>> 2)) ||
                        (t_wide'(r_xp2) + t_wide'(r_yy) <= FX_SIXTEENTH);

    assign w_sum    = t_wide'(r_zr2) + t_wide'(r_zi2);
    assign w_zi_new = (t_wide'(r_p) <<< 1) + r_ci;
    assign w_zr_new = t_wide'(r_zr2) - t_wide'(r_zi2) + r_cr;
    assign w_big    = (w_zr_new >= FX_TWO) || (w_zr_new <= -FX_TWO) ||
                      (w_zi_new >= FX_TWO) || (w_zi_new <= -FX_TWO);

    assign w_cnt_next   = r_count + CNTW'(1);
    assign w_shade_next = (r_shade == CNTW'(SHADES - 1)) ? '0 : r_shade + CNTW'(1);

    assign w_out_free = !r_out_valid || i_m_tready;

    // ------------------------------------------------------------------------
    // Sequencer: next state, multiplier issue and register updates
    // ------------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_cr        = r_cr;
        n_ci        = r_ci;
        n_xm        = r_xm;
        n_xp        = r_xp;
        n_yy        = r_yy;
        n_xm2       = r_xm2;
        n_xp2       = r_xp2;
        n_q         = r_q;
        n_qx        = r_qx;
        n_card      = r_card;
        n_zr        = r_zr;
        n_zi        = r_zi;
        n_zr2       = r_zr2;
        n_zi2       = r_zi2;
        n_p         = r_p;
        n_count     = r_count;
        n_shade     = r_shade;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_count = r_out_count;
        n_out_black = r_out_black;
        n_out_shade = r_out_shade;
        w_req       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_dx    = w_col_dx;
                    n_dy    = w_row_dy;
                    n_state = S_MAP0;
                end
            end
            S_MAP0: begin
                w_req.valid = 1'b1;
                w_req.dst   = DST_CR;
                w_req.a     = OPW'(r_dx);
                w_req.b     = OPW'({1'b0, r_step});
                n_state     = S_MAP1;
            end
            S_MAP1: begin
                w_req.valid = 1'b1;
                w_req.dst   = DST_CI;
                w_req.a     = OPW'(r_dy);
                w_req.b     = OPW'({1'b0, r_step});
                n_state     = S_MAP_W;
            end
            S_MAP_W: begin
                if (!w_rsp.pending) begin
                    n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                // start z at zero; the first update then yields z = c
                n_count = '0;
                n_shade = '0;
                n_zr2   = '0;
                n_zi2   = '0;
                n_p     = '0;
                n_xm    = OPW'(r_cr - FX_QUARTER);
                n_xp    = OPW'(r_cr + FX_ONE);
                if (w_in_range) begin
                    w_req.valid = 1'b1;
                    w_req.shift = 1'b1;
                    w_req.dst   = DST_YY;
                    w_req.a     = OPW'(r_ci);
                    w_req.b     = OPW'(r_ci);
                    n_state     = S_INT1;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_INT1: begin
                w_req.valid = 1'b1;
                w_req.shift = 1'b1;
                w_req.dst   = DST_XM2;
                w_req.a     = r_xm;
                w_req.b     = r_xm;
                n_state     = S_INT2;
            end
            S_INT2: begin
                w_req.valid = 1'b1;
                w_req.shift = 1'b1;
                w_req.dst   = DST_XP2;
                w_req.a     = r_xp;
                w_req.b     = r_xp;
                n_state     = S_INT_W1;
            end
            S_INT_W1: begin
                if (!w_rsp.pending) begin
                    n_state = S_INTQ;
                end
            end
            S_INTQ: begin
                n_q     = r_xm2 + r_yy;
                n_state = S_INTQX;
            end
            S_INTQX: begin
                n_qx    = r_q + r_xm;
                n_state = S_INT3;
            end
            S_INT3: begin
                w_req.valid = 1'b1;
                w_req.shift = 1'b1;
                w_req.dst   = DST_CARD;
                w_req.a     = r_q;
                w_req.b     = r_qx;
                n_state     = S_INT_W2;
            end
            S_INT_W2: begin
                if (!w_rsp.pending) begin
                    n_state = S_INTDEC;
                end
            end
            S_INTDEC: begin
                if (w_interior) begin
                    n_count = CNTW'(MAX_ITER);
                    n_shade = CNTW'(MAX_ITER % SHADES);
                    n_state = S_DONE;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // the squared-magnitude test belongs to the previous update
                if (w_sum >= FX_FOUR) begin
                    n_state = S_DONE;
                end else begin
                    n_zr    = OPW'(w_zr_new);
                    n_zi    = OPW'(w_zi_new);
                    n_count = w_cnt_next;
                    n_shade = w_shade_next;
                    if (w_cnt_next == CNTW'(MAX_ITER) || w_big) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_IT0;
                    end
                end
            end
            S_IT0: begin
                w_req.valid = 1'b1;
                w_req.shift = 1'b1;
                w_req.dst   = DST_ZR2;
                w_req.a     = r_zr;
                w_req.b     = r_zr;
                n_state     = S_IT1;
            end
            S_IT1: begin
                w_req.valid = 1'b1;
                w_req.shift = 1'b1;
                w_req.dst   = DST_ZI2;
                w_req.a     = r_zi;
                w_req.b     = r_zi;
                n_state     = S_IT2;
            end
            S_IT2: begin
                w_req.valid = 1'b1;
                w_req.shift = 1'b1;
                w_req.dst   = DST_P;
                w_req.a     = r_zr;
                w_req.b     = r_zi;
                n_state     = S_IT_W;
            end
            S_IT_W: begin
                if (!w_rsp.pending) begin
                    n_state = S_UPD;
                end
            end
            S_DONE: begin
                // hold the result until the output register frees
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_count;
                    n_out_black = (r_count >= CNTW'(MAX_ITER));
                    n_out_shade = r_shade[3:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // capture products by their destination tag
        if (w_rsp.valid) begin
            case (w_rsp.dst)
                DST_CR:   n_cr   = w_rsp.value + t_wide'(r_cen_re);
                DST_CI:   n_ci   = w_rsp.value + t_wide'(r_cen_im);
                DST_YY:   n_yy   = OPW'(w_rsp.value);
                DST_XM2:  n_xm2  = OPW'(w_rsp.value);
                DST_XP2:  n_xp2  = OPW'(w_rsp.value);
                DST_CARD: n_card = w_rsp.value;
                DST_ZR2:  n_zr2  = OPW'(w_rsp.value);
                DST_ZI2:  n_zi2  = OPW'(w_rsp.value);
                DST_P:    n_p    = OPW'(w_rsp.value);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_cr        <= n_cr;
        r_ci        <= n_ci;
        r_xm        <= n_xm;
        r_xp        <= n_xp;
        r_yy        <= n_yy;
        r_xm2       <= n_xm2;
        r_xp2       <= n_xp2;
        r_q         <= n_q;
        r_qx        <= n_qx;
        r_card      <= n_card;
        r_zr        <= n_zr;
        r_zi        <= n_zi;
        r_zr2       <= n_zr2;
        r_zi2       <= n_zi2;
        r_p         <= n_p;
        r_count     <= n_count;
        r_shade     <= n_shade;
        r_out_count <= n_out_count;
        r_out_black <= n_out_black;
        r_out_shade <= n_out_shade;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_shade, r_out_black, r_out_count};

`ifndef SYNTHESIS
    // one pixel at a time: an accepted word closes the input
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while a pixel is in flight");

    // the shared multiplier is drained whenever the core is idle
    a_mul_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_rsp.valid && !w_rsp.pending))
        else $error("multiplier busy while idle");

    // a finished pixel reaches a free output register in the next cycle
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !o_m_tvalid) |=> o_m_tvalid)
        else $error("finished pixel not loaded into free output register");

    // black exactly when the count reached the limit
    a_black_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[8] == (o_m_tdata[7:0] == CNTW'(MAX_ITER))))
        else $error("black flag disagrees with iteration count");
`endif

endmodule

// File: src/mbet_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot shared multiplier
// Two-stage sign-magnitude multiplier: magnitudes in stage one, a 32x32
// product in stage two, truncation toward zero and sign on the way out.
// ----------------------------------------------------------------------------
module mbet_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbet_pkg::t_mul_req i_req,
    output mbet_pkg::t_mul_rsp o_rsp
);
    import mbet_pkg::*;

    t_opnd             w_a_abs;
    t_opnd             w_b_abs;
    logic              r_s1_valid;
    logic              r_s1_shift;
    t_dst              r_s1_dst;
    logic              r_s1_neg;
    logic [MAGW-1:0]   r_s1_a;
    logic [MAGW-1:0]   r_s1_b;
    logic              r_s2_valid;
    logic              r_s2_shift;
    t_dst              r_s2_dst;
    logic              r_s2_neg;
    logic [PRODW-1:0]  r_s2_prod;
    logic [WW-2:0]     w_mag;
    t_wide             w_mag_s;

    assign w_a_abs = i_req.a[OPW-1] ? -i_req.a : i_req.a;
    assign w_b_abs = i_req.b[OPW-1] ? -i_req.b : i_req.b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_shift <= i_req.shift;
        r_s1_dst   <= i_req.dst;
        r_s1_neg   <= i_req.a[OPW-1] ^ i_req.b[OPW-1];
        r_s1_a     <= w_a_abs[MAGW-1:0];
        r_s1_b     <= w_b_abs[MAGW-1:0];
        r_s2_shift <= r_s1_shift;
        r_s2_dst   <= r_s1_dst;
        r_s2_neg   <= r_s1_neg;
        r_s2_prod  <= PRODW'(r_s1_a) * PRODW'(r_s1_b);
    end

    // Truncate the magnitude, then apply the sign: rounds toward zero.
    assign w_mag   = r_s2_shift ? (WW-1)'(r_s2_prod[PRODW-1:FRAC_BITS])
                                : r_s2_prod[WW-2:0];
    assign w_mag_s = t_wide'({1'b0, w_mag});

    assign o_rsp.valid   = r_s2_valid;
    assign o_rsp.pending = r_s1_valid;
    assign o_rsp.dst     = r_s2_dst;
    assign o_rsp.value   = r_s2_neg ? -w_mag_s : w_mag_s;

endmodule
